### rtl/core/mnee_pkg.sv
package mnee_pkg;

    localparam int unsigned NoteWidth   = 7;
    localparam int unsigned TpbWidth    = 16;
    localparam int unsigned MpbWidth    = 24;
    localparam int unsigned DeltaWidth  = 28;
    localparam int unsigned ClockWidth  = 32;
    localparam int unsigned ProdWidth   = DeltaWidth + MpbWidth;
    localparam int unsigned DivSteps    = ProdWidth;
    localparam int unsigned DivCntWidth = $clog2(DivSteps + 1);

    localparam logic [3:0] HdrByteCount   = 4'd10;
    localparam logic [3:0] TempoByteCount = 4'd3;

    localparam logic [7:0] ByteMetaFf  = 8'hff;
    localparam logic [7:0] ByteTempo   = 8'h51;
    localparam logic [7:0] ByteTlen    = 8'h03;
    localparam logic [7:0] ByteEot     = 8'h2f;
    localparam logic [7:0] ByteCtrlB0  = 8'hb0;
    localparam logic [7:0] ByteNoteOn0 = 8'h90;
    localparam logic [7:0] ByteNoteOn5 = 8'h95;
    localparam logic [7:0] ByteA4      = 8'h45;
    localparam logic [7:0] ByteZero    = 8'h00;
    localparam logic [7:0] ByteCont    = 8'h80;

    localparam logic [NoteWidth-1:0] NoteResetA = 7'd69;
    localparam logic [NoteWidth-1:0] NoteResetB = 7'd71;
    localparam logic [NoteWidth-1:0] NoteResetC = 7'd72;
    localparam logic [NoteWidth-1:0] NoteResetD = 7'd74;

    localparam logic [1:0] CfgNoteA = 2'd0;
    localparam logic [1:0] CfgNoteB = 2'd1;
    localparam logic [1:0] CfgNoteC = 2'd2;
    localparam logic [1:0] CfgNoteD = 2'd3;

    typedef enum logic [3:0] {
        PH_HDR,
        PH_HDRBYTES,
        PH_TRK,
        PH_TEMPO,
        PH_TEMPOVAL,
        PH_FIRST,
        PH_DELTA,
        PH_EXTRA,
        PH_NOTE,
        PH_VEL,
        PH_TLEN,
        PH_TVAL,
        PH_SKIP,
        PH_DIV,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic shift;
        logic load_tpb;
        logic mpb_shift;
        logic delta_clr;
        logic delta_shift;
        logic div_start;
        logic event_load;
        logic emit_note;
        logic emit_fin;
    } cmd_t;

    typedef struct packed {
        logic       out_busy;
        logic       hdr_tag;
        logic       trk_tag;
        logic       tempo_tag;
        logic       first_tag;
        logic       end_tag;
        logic       cont_bit;
        logic       ev_tempo;
        logic       ev_ctrl;
        logic       note_match;
        logic       div_done;
    } status_t;

endpackage

### rtl/core/mnee_ctrl.sv
module mnee_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tlast,
    input  mnee_pkg::status_t sts,
    output mnee_pkg::cmd_t    cmd
);

    mnee_pkg::phase_t state_reg, state_next;
    logic [3:0]       step_reg, step_next;
    logic             pend_reg, pend_next;
    logic             acc;
    logic [3:0]       step_inc;

    assign s_tready = (state_reg != mnee_pkg::PH_DIV) && !sts.out_busy;
    assign acc      = s_tvalid && s_tready;
    assign step_inc = step_reg + 4'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mnee_pkg::PH_HDR;
            step_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        if (state_reg == mnee_pkg::PH_DIV) begin
            if (sts.div_done) begin
                state_next = pend_reg ? mnee_pkg::PH_EXTRA : mnee_pkg::PH_NOTE;
            end
        end else if (acc && state_reg != mnee_pkg::PH_DONE) begin
            if (s_tlast) begin
                cmd.emit_fin = 1'b1;
                state_next   = mnee_pkg::PH_DONE;
            end else begin
                cmd.shift = 1'b1;
                unique case (state_reg)
                    mnee_pkg::PH_HDR: begin
                        if (sts.hdr_tag) begin
                            state_next = mnee_pkg::PH_HDRBYTES;
                            step_next  = '0;
                        end
                    end
                    mnee_pkg::PH_HDRBYTES: begin
                        step_next = step_inc;
                        if (step_inc >= mnee_pkg::HdrByteCount) begin
                            cmd.load_tpb = 1'b1;
                            if (sts.trk_tag && sts.tempo_tag) begin
                                state_next = mnee_pkg::PH_TEMPOVAL;
                                step_next  = '0;
                            end else if (sts.trk_tag) begin
                                state_next = mnee_pkg::PH_TEMPO;
                            end else begin
                                state_next = mnee_pkg::PH_TRK;
                            end
                        end
                    end
                    mnee_pkg::PH_TRK: begin
                        if (sts.trk_tag && sts.tempo_tag) begin
                            state_next = mnee_pkg::PH_TEMPOVAL;
                            step_next  = '0;
                        end else if (sts.trk_tag) begin
                            state_next = mnee_pkg::PH_TEMPO;
                        end
                    end
                    mnee_pkg::PH_TEMPO: begin
                        if (sts.tempo_tag) begin
                            state_next = mnee_pkg::PH_TEMPOVAL;
                            step_next  = '0;
                        end
                    end
                    mnee_pkg::PH_FIRST: begin
                        if (sts.first_tag) begin
                            state_next    = mnee_pkg::PH_DELTA;
                            cmd.delta_clr = 1'b1;
                        end
                    end
                    mnee_pkg::PH_TEMPOVAL, mnee_pkg::PH_TVAL: begin
                        cmd.mpb_shift = 1'b1;
                        step_next     = step_inc;
                        if (step_inc >= mnee_pkg::TempoByteCount) begin
                            if (state_reg == mnee_pkg::PH_TEMPOVAL) begin
                                if (sts.first_tag) begin
                                    state_next    = mnee_pkg::PH_DELTA;
                                    cmd.delta_clr = 1'b1;
                                end else begin
                                    state_next = mnee_pkg::PH_FIRST;
                                end
                            end else if (sts.end_tag) begin
                                cmd.emit_fin = 1'b1;
                                state_next   = mnee_pkg::PH_DONE;
                            end else begin
                                state_next    = mnee_pkg::PH_DELTA;
                                cmd.delta_clr = 1'b1;
                            end
                        end
                    end
                    mnee_pkg::PH_DELTA: begin
                        if (sts.cont_bit) begin
                            cmd.delta_shift = 1'b1;
                        end else begin
                            cmd.div_start = 1'b1;
                            state_next    = mnee_pkg::PH_DIV;
                        end
                    end
                    mnee_pkg::PH_EXTRA: begin
                        pend_next  = 1'b0;
                        state_next = mnee_pkg::PH_NOTE;
                    end
                    mnee_pkg::PH_NOTE: begin
                        cmd.event_load = 1'b1;
                        state_next     = mnee_pkg::PH_VEL;
                    end
                    mnee_pkg::PH_VEL: begin
                        priority if (sts.ev_tempo) begin
                            pend_next  = 1'b1;
                            state_next = mnee_pkg::PH_TLEN;
                        end else if (sts.ev_ctrl) begin
                            state_next = mnee_pkg::PH_SKIP;
                        end else if (sts.note_match) begin
                            cmd.emit_note = 1'b1;
                            cmd.delta_clr = 1'b1;
                            state_next    = mnee_pkg::PH_DELTA;
                        end else if (sts.end_tag) begin
                            cmd.emit_fin = 1'b1;
                            state_next   = mnee_pkg::PH_DONE;
                        end else begin
                            cmd.delta_clr = 1'b1;
                            state_next    = mnee_pkg::PH_DELTA;
                        end
                    end
                    mnee_pkg::PH_TLEN: begin
                        state_next = mnee_pkg::PH_TVAL;
                        step_next  = '0;
                    end
                    mnee_pkg::PH_SKIP: begin
                        pend_next = 1'b1;
                        if (sts.end_tag) begin
                            cmd.emit_fin = 1'b1;
                            state_next   = mnee_pkg::PH_DONE;
                        end else begin
                            cmd.delta_clr = 1'b1;
                            state_next    = mnee_pkg::PH_DELTA;
                        end
                    end
                    default: begin
                        state_next = mnee_pkg::PH_DONE;
                    end
                endcase
            end
        end
    end

    a_div_enters_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> state_reg == mnee_pkg::PH_DIV)
        else $error("divide start did not enter wait");

    a_fin_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_fin |=> state_reg == mnee_pkg::PH_DONE)
        else $error("finished result without end state");

    a_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mnee_pkg::PH_DONE |=> state_reg == mnee_pkg::PH_DONE)
        else $error("left end state");

    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.emit_fin && cmd.emit_note))
        else $error("two results in one transfer");

endmodule

### rtl/core/mnee_dpath.sv
module mnee_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [7:0]                        data_byte,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [mnee_pkg::NoteWidth-1:0]    cfg_wr_data,
    input  mnee_pkg::cmd_t                    cmd,
    output mnee_pkg::status_t                 sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,
    output logic                              m_tlast
);

    logic [7:0]                         win_reg [4];
    logic [mnee_pkg::NoteWidth-1:0]     note_reg [4];
    logic [mnee_pkg::TpbWidth-1:0]      tpb_reg;
    logic [mnee_pkg::MpbWidth-1:0]      mpb_reg;
    logic [mnee_pkg::DeltaWidth-1:0]    delta_reg, delta_next;
    logic [mnee_pkg::ClockWidth-1:0]    clock_reg;
    logic [7:0]                         event_reg;
    logic [mnee_pkg::ProdWidth-1:0]     dvd_reg;
    logic [mnee_pkg::TpbWidth-1:0]      rem_reg;
    logic [mnee_pkg::TpbWidth-1:0]      dvs_reg;
    logic [mnee_pkg::DivCntWidth-1:0]   cnt_reg;
    logic                               busy_reg;
    logic [mnee_pkg::TpbWidth:0]        trial;
    logic [mnee_pkg::TpbWidth:0]        diff;
    logic                               qbit;
    logic                               div_last;
    logic                               out_valid_reg;
    logic [1:0]                         light_reg;
    logic [mnee_pkg::ClockWidth-1:0]    time_reg;
    logic [7:0]                         strength_reg;
    logic                               fin_reg;
    logic [1:0]                         light_sel;
    logic [3:0]                         hit;

    assign delta_next = {delta_reg[mnee_pkg::DeltaWidth-8:0], data_byte[6:0]};

    assign hit[0] = event_reg == {1'b0, note_reg[0]};
    assign hit[1] = event_reg == {1'b0, note_reg[1]};
    assign hit[2] = event_reg == {1'b0, note_reg[2]};
    assign hit[3] = event_reg == {1'b0, note_reg[3]};

    always_comb begin
        priority if (hit[0]) begin
            light_sel = 2'd0;
        end else if (hit[1]) begin
            light_sel = 2'd1;
        end else if (hit[2]) begin
            light_sel = 2'd2;
        end else begin
            light_sel = 2'd3;
        end
    end

    // tags are checked on the window after the new byte
    always_comb begin
        sts.out_busy   = out_valid_reg && !m_tready;
        sts.hdr_tag    = win_reg[1] == "M" && win_reg[2] == "T" && win_reg[3] == "h"
                         && data_byte == "d";
        sts.trk_tag    = win_reg[1] == "M" && win_reg[2] == "T" && win_reg[3] == "r"
                         && data_byte == "k";
        sts.tempo_tag  = win_reg[2] == mnee_pkg::ByteMetaFf && win_reg[3] == mnee_pkg::ByteTempo
                         && data_byte == mnee_pkg::ByteTlen;
        sts.first_tag  = (win_reg[2] == mnee_pkg::ByteNoteOn0
                          || win_reg[2] == mnee_pkg::ByteNoteOn5)
                         && win_reg[3] == mnee_pkg::ByteA4 && data_byte == mnee_pkg::ByteZero;
        sts.end_tag    = win_reg[3] == mnee_pkg::ByteMetaFf && data_byte == mnee_pkg::ByteEot;
        sts.cont_bit   = (data_byte & mnee_pkg::ByteCont) != 8'd0;
        sts.ev_tempo   = event_reg == mnee_pkg::ByteMetaFf && data_byte == mnee_pkg::ByteTempo;
        sts.ev_ctrl    = event_reg == mnee_pkg::ByteCtrlB0;
        sts.note_match = |hit;
        sts.div_done   = div_last;
    end

    assign trial    = {rem_reg, dvd_reg[mnee_pkg::ProdWidth-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign qbit     = trial >= {1'b0, dvs_reg};
    assign div_last = busy_reg && (cnt_reg == mnee_pkg::DivCntWidth'(mnee_pkg::DivSteps));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
            win_reg[3] <= '0;
            note_reg[0] <= mnee_pkg::NoteResetA;
            note_reg[1] <= mnee_pkg::NoteResetB;
            note_reg[2] <= mnee_pkg::NoteResetC;
            note_reg[3] <= mnee_pkg::NoteResetD;
            tpb_reg       <= '0;
            mpb_reg       <= '0;
            delta_reg     <= '0;
            clock_reg     <= '0;
            event_reg     <= '0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    mnee_pkg::CfgNoteA: note_reg[0] <= cfg_wr_data;
                    mnee_pkg::CfgNoteB: note_reg[1] <= cfg_wr_data;
                    mnee_pkg::CfgNoteC: note_reg[2] <= cfg_wr_data;
                    mnee_pkg::CfgNoteD: note_reg[3] <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.shift) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= win_reg[3];
                win_reg[3] <= data_byte;
            end
            if (cmd.load_tpb) begin
                tpb_reg <= {win_reg[3], data_byte};
            end
            if (cmd.mpb_shift) begin
                mpb_reg <= {mpb_reg[mnee_pkg::MpbWidth-9:0], data_byte};
            end
            if (cmd.delta_clr || cmd.div_start) begin
                delta_reg <= '0;
            end else if (cmd.delta_shift) begin
                delta_reg <= delta_next;
            end
            if (cmd.event_load) begin
                event_reg <= data_byte;
            end
            if (cmd.div_start) begin
                dvd_reg  <= delta_next * mpb_reg;
                rem_reg  <= '0;
                dvs_reg  <= (tpb_reg == '0) ? mnee_pkg::TpbWidth'(1) : tpb_reg;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (div_last) begin
                clock_reg <= clock_reg + dvd_reg[mnee_pkg::ClockWidth-1:0];
                busy_reg  <= 1'b0;
            end else if (busy_reg) begin
                rem_reg <= qbit ? diff[mnee_pkg::TpbWidth-1:0] : trial[mnee_pkg::TpbWidth-1:0];
                dvd_reg <= {dvd_reg[mnee_pkg::ProdWidth-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.emit_note || cmd.emit_fin) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_note) begin
            light_reg    <= light_sel;
            time_reg     <= clock_reg;
            strength_reg <= data_byte;
            fin_reg      <= 1'b0;
        end else if (cmd.emit_fin) begin
            light_reg    <= '0;
            time_reg     <= clock_reg;
            strength_reg <= '0;
            fin_reg      <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, strength_reg, time_reg, light_reg};
    assign m_tlast  = fin_reg;

endmodule

### rtl/core/midi_note_event_extractor_unit.sv
// channel  | direction | tdata (low bit up)                       | tlast
// s_       | in        | data_byte[7:0]                           | end_of_input
// m_       | out       | light[1:0], event_time_us[33:2],         | finished
//          |           | strength[41:34], zero[47:42]             |
// cfg_     | in        | cfg_index selects note_light_a..d        | -
// One byte per cycle, except while the 52-step serial divider runs after a final delta-time byte.
// The result register decouples the sides; input also stalls while it is held full.
// Reset is synchronous, active low; clears all parse state and restores note numbers.
// After a finished result, further bytes are taken and dropped.
module midi_note_event_extractor_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // light, event_time_us, strength
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wr_data
);

    mnee_pkg::cmd_t    cmd;
    mnee_pkg::status_t sts;

    mnee_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    mnee_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .data_byte   (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

### sim/tb_midi_note_event_extractor_unit.sv
module tb_midi_note_event_extractor_unit;

    typedef struct packed {
        logic       fin;
        logic [7:0] strength;
        logic [31:0] time_us;
        logic [1:0] light;
    } note_event_t;

    typedef struct packed {
        logic       eoi;
        logic [7:0] data;
    } midi_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = mnee_pkg::CfgNoteA;
    logic [6:0]  cfg_wr_data = 7'd0;

    midi_note_event_extractor_unit DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    mnee_pkg::phase_t ph;
    logic [7:0]   win [4];
    logic [3:0]   cnt;
    logic [15:0]  tpb;
    logic [23:0]  mpb;
    logic [27:0]  dticks;
    logic [31:0]  clk_us;
    logic         pend;
    logic [7:0]   ev_code;
    logic [6:0]   notes [4];

    midi_byte_t   byte_q [$];
    note_event_t  event_q [$];
    int           errors = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           hold_cycles = 0;
    int           quiet = 0;

    function automatic bit tail3(logic [7:0] x, logic [7:0] y, logic [7:0] z);
        return win[1] == x && win[2] == y && win[3] == z;
    endfunction

    task automatic parser_reset();
        notes[0] = mnee_pkg::NoteResetA; notes[1] = mnee_pkg::NoteResetB;
        notes[2] = mnee_pkg::NoteResetC; notes[3] = mnee_pkg::NoteResetD;
        ph = mnee_pkg::PH_HDR;
        foreach (win[i]) win[i] = 8'd0;
        cnt = 0; tpb = 0; mpb = 0; dticks = 0; clk_us = 0; pend = 0; ev_code = 0;
    endtask

    task automatic enter_phase(mnee_pkg::phase_t p);
        ph = p;
        if (ph == mnee_pkg::PH_TRK && win[0] == "M" && tail3("T", "r", "k"))
            ph = mnee_pkg::PH_TEMPO;
        if (ph == mnee_pkg::PH_TEMPO &&
            tail3(mnee_pkg::ByteMetaFf, mnee_pkg::ByteTempo, mnee_pkg::ByteTlen)) begin
            ph = mnee_pkg::PH_TEMPOVAL;
            cnt = 0;
            return;
        end
        if (ph == mnee_pkg::PH_FIRST &&
            (tail3(mnee_pkg::ByteNoteOn0, mnee_pkg::ByteA4, mnee_pkg::ByteZero) ||
             tail3(mnee_pkg::ByteNoteOn5, mnee_pkg::ByteA4, mnee_pkg::ByteZero))) begin
            ph = mnee_pkg::PH_DELTA;
            dticks = 0;
        end
    endtask

    task automatic push_event(logic [1:0] l, logic [7:0] s, logic f);
        note_event_t e;
        e.light = l; e.time_us = clk_us; e.strength = s; e.fin = f;
        event_q.push_back(e);
    endtask

    task automatic finish_track();
        ph = mnee_pkg::PH_DONE;
        push_event(2'd0, 8'd0, 1'b1);
    endtask

    task automatic end_check();
        if (win[2] == mnee_pkg::ByteMetaFf && win[3] == mnee_pkg::ByteEot) finish_track();
        else begin
            ph = mnee_pkg::PH_DELTA;
            dticks = 0;
        end
    endtask

    task automatic parse_byte(midi_byte_t it);
        logic [7:0]  b;
        logic [63:0] prod;
        logic [63:0] dv;
        b = it.data;
        if (ph == mnee_pkg::PH_DONE) return;
        if (it.eoi) begin
            finish_track();
            return;
        end
        win[0] = win[1]; win[1] = win[2]; win[2] = win[3]; win[3] = b;
        case (ph)
            mnee_pkg::PH_HDR: begin
                if (win[0] == "M" && tail3("T", "h", "d")) begin
                    ph = mnee_pkg::PH_HDRBYTES;
                    cnt = 0;
                end
            end
            mnee_pkg::PH_HDRBYTES: begin
                cnt = cnt + 4'd1;
                if (cnt >= mnee_pkg::HdrByteCount) begin
                    tpb = {win[2], win[3]};
                    enter_phase(mnee_pkg::PH_TRK);
                end
            end
            mnee_pkg::PH_TRK, mnee_pkg::PH_TEMPO, mnee_pkg::PH_FIRST: enter_phase(ph);
            mnee_pkg::PH_TEMPOVAL, mnee_pkg::PH_TVAL: begin
                mpb = {mpb[15:0], b};
                cnt = cnt + 4'd1;
                if (cnt >= mnee_pkg::TempoByteCount) begin
                    if (ph == mnee_pkg::PH_TEMPOVAL) enter_phase(mnee_pkg::PH_FIRST);
                    else end_check();
                end
            end
            mnee_pkg::PH_DELTA: begin
                dticks = {dticks[20:0], b[6:0]};
                if (!b[7]) begin
                    dv = (tpb == 0) ? 64'd1 : 64'(tpb);
                    prod = 64'(dticks) * 64'(mpb);
                    clk_us = clk_us + 32'(prod / dv);
                    dticks = 0;
                    ph = pend ? mnee_pkg::PH_EXTRA : mnee_pkg::PH_NOTE;
                end
            end
            mnee_pkg::PH_EXTRA: begin
                pend = 0;
                ph = mnee_pkg::PH_NOTE;
            end
            mnee_pkg::PH_NOTE: begin
                ev_code = b;
                ph = mnee_pkg::PH_VEL;
            end
            mnee_pkg::PH_VEL: begin
                if (ev_code == mnee_pkg::ByteMetaFf && b == mnee_pkg::ByteTempo) begin
                    pend = 1;
                    ph = mnee_pkg::PH_TLEN;
                end else if (ev_code == mnee_pkg::ByteCtrlB0) begin
                    ph = mnee_pkg::PH_SKIP;
                end else begin
                    bit hit;
                    hit = 0;
                    for (int i = 0; i < 4; i++) begin
                        if (!hit && ev_code == {1'b0, notes[i]}) begin
                            push_event(2'(i), b, 1'b0);
                            ph = mnee_pkg::PH_DELTA;
                            dticks = 0;
                            hit = 1;
                        end
                    end
                    if (!hit) end_check();
                end
            end
            mnee_pkg::PH_TLEN: begin
                ph = mnee_pkg::PH_TVAL;
                cnt = 0;
            end
            mnee_pkg::PH_SKIP: begin
                pend = 1;
                end_check();
            end
            default: ph = mnee_pkg::PH_DONE;
        endcase
    endtask

    // stimulus building
    task automatic add(logic [7:0] b);
        byte_q.push_back('{eoi: 1'b0, data: b});
    endtask

    task automatic add_eoi();
        byte_q.push_back('{eoi: 1'b1, data: 8'($urandom)});
    endtask

    task automatic add_delta();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : $urandom_range(1, 2);
        repeat (n - 1) add(8'($urandom) | mnee_pkg::ByteCont);
        add(8'($urandom) & 8'h7f);
    endtask

    task automatic add_body(int events);
        int k;
        for (int e = 0; e < events; e++) begin
            add_delta();
            k = $urandom_range(0, 9);
            if (k < 6) begin
                add(8'(notes[2'($urandom_range(0, 3))]));
                add(8'($urandom));
            end else if (k == 6) begin
                add(mnee_pkg::ByteMetaFf); add(mnee_pkg::ByteTempo); add(mnee_pkg::ByteTlen);
                add(8'($urandom)); add(8'($urandom)); add(8'($urandom));
                add(8'($urandom));
            end else if (k == 7) begin
                add(mnee_pkg::ByteCtrlB0); add(8'($urandom)); add(8'($urandom));
                add(8'($urandom));
            end else begin
                add(8'($urandom)); add(8'($urandom));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid && s_tready) parse_byte('{eoi: s_tlast, data: s_tdata});
            if (byte_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                midi_byte_t it;
                it = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= it.data;
                s_tlast <= it.eoi;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                note_event_t got, want;
                got = {m_tlast, m_tdata[41:34], m_tdata[33:2], m_tdata[1:0]};
                if (event_q.size() == 0) begin
                    errors++;
                    $display("%0t expected no result got %h", $time, got);
                end else begin
                    want = event_q.pop_front();
                    if (got.light !== want.light || got.time_us !== want.time_us ||
                        got.strength !== want.strength || got.fin !== want.fin) begin
                        errors++;
                        $display("%0t expected l=%0d t=%0d s=%0d f=%0b got l=%0d t=%0d s=%0d f=%0b",
                                 $time, want.light, want.time_us, want.strength, want.fin,
                                 got.light, got.time_us, got.strength, got.fin);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_note(logic [1:0] idx, logic [6:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        notes[idx] = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (byte_q.size() > 0 || s_tvalid || event_q.size() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    initial begin
        parser_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        m_tready <= 1'b1;

        // directed: max tempo, long delta, duplicate notes, extra status handling
        write_note(mnee_pkg::CfgNoteA, 7'd0);
        write_note(mnee_pkg::CfgNoteB, 7'd127);
        write_note(mnee_pkg::CfgNoteC, 7'd127);
        write_note(mnee_pkg::CfgNoteD, 7'd60);
        add("M"); add("T"); add("h"); add("d");
        repeat (8) add(8'h00);
        add(8'h00); add(8'h60);
        add("M"); add("T"); add("r"); add("k");
        add(mnee_pkg::ByteMetaFf); add(mnee_pkg::ByteTempo); add(mnee_pkg::ByteTlen);
        add(8'hff); add(8'hff); add(8'hff);
        add(mnee_pkg::ByteNoteOn5); add(mnee_pkg::ByteA4); add(mnee_pkg::ByteZero);
        add(8'hff); add(8'hff); add(8'hff); add(8'hff); add(8'h7f);
        add(8'h7f); add(8'hff);
        add(8'h00); add(8'h00); add(8'h00);
        add(8'h00); add(mnee_pkg::ByteCtrlB0); add(8'h01); add(8'h55);
        add(8'h01); add(8'h3c); add(8'h80);
        add(8'h00); add(mnee_pkg::ByteMetaFf); add(mnee_pkg::ByteTempo);
        add(mnee_pkg::ByteTlen);
        add(8'h00); add(8'h00); add(8'h01); add(8'h12);
        drain();

        // random events on the same track, one phase per idling pattern
        write_note(mnee_pkg::CfgNoteA, mnee_pkg::NoteResetA);
        write_note(mnee_pkg::CfgNoteB, mnee_pkg::NoteResetB);
        write_note(mnee_pkg::CfgNoteC, mnee_pkg::NoteResetC);
        write_note(mnee_pkg::CfgNoteD, mnee_pkg::NoteResetD);
        for (int p = 0; p < 4; p++) begin
            idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 77 : 25) : 0;
            stall_pct = (p == 2) ? 77 : ((p == 3) ? 25 : 0);
            if (p == 0) hold_cycles = 3000;
            add_body(75);
            drain();
            write_note(2'(p), 7'($urandom));
        end

        // end of track, then end of input; bytes after the end are dropped
        add_delta(); add(mnee_pkg::ByteMetaFf); add(mnee_pkg::ByteEot);
        add_eoi();
        repeat (3) add(8'($urandom));
        drain();
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
rtl/core/mnee_pkg.sv
rtl/core/mnee_ctrl.sv
rtl/core/mnee_dpath.sv
rtl/core/midi_note_event_extractor_unit.sv
sim/tb_midi_note_event_extractor_unit.sv
